@@ src/lobm_pkg.sv @@
// Shared types, constants and helpers for the limit order book matcher.
// No dependencies; every other file in src imports this package.
package lobm_pkg;

	localparam int STOCK_COUNT_DEF = 16;
	localparam int BOOK_DEPTH_DEF  = 32;

	localparam int STOCK_W  = 4;
	localparam int TRADER_W = 8;
	localparam int PRICE_W  = 31;
	localparam int AMT_W    = 31;
	localparam int SEQ_W    = 32;
	localparam int SLOT_W   = 6;   // holds any slot number up to the largest depth

	localparam int STOCK_CODES = 1 << STOCK_W;

	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 144;

	// One resting order in a book slot
	typedef struct packed {
		logic                vld;
		logic [PRICE_W-1:0]  price;
		logic [AMT_W-1:0]    amount;
		logic [TRADER_W-1:0] trader;
		logic [SEQ_W-1:0]    seq;
	} entry_t;

	// Sort key carried along the cell chain
	typedef struct packed {
		logic               vld;
		logic [PRICE_W-1:0] price;
		logic [SEQ_W-1:0]   age;
		logic [SLOT_W-1:0]  idx;
	} key_t;

	// Per-cycle command to every cell of the chain
	typedef struct packed {
		logic clr;
		logic ins;
		logic pop;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_SORT,
		ST_MATCH,
		ST_CLOSE
	} state_t;

	// Priority of a over b against an incoming order of the given side:
	// better price, then older arrival, then lower slot.
	function automatic logic key_better(input logic is_buy, input key_t a, input key_t b);
		logic res;
		if (a.price != b.price) begin
			res = is_buy ? (a.price < b.price) : (a.price > b.price);
		end else if (a.age != b.age) begin
			res = a.age > b.age;
		end else begin
			res = a.idx < b.idx;
		end
		return res;
	endfunction

endpackage

@@ src/lobm_cell.sv @@
// One cell of the insertion-sort chain: keeps the best key seen, passes the other on.
// Depends on lobm_pkg.
module lobm_cell
	import lobm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      is_buy,
	input  key_t      in_key,   // from left neighbor (or feed)
	input  key_t      nxt_key,  // right neighbor's held key, for pops
	output key_t      held,
	output key_t      pass
);

	logic take;

	// incoming key displaces the held one
	assign take = in_key.vld && (!held.vld || key_better(is_buy, in_key, held));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held <= '0;
			pass <= '0;
		end else if (ctl.clr) begin
			held.vld <= 1'b0;
			pass.vld <= 1'b0;
		end else if (ctl.ins) begin
			if (take) begin
				held <= in_key;
				pass <= held;
			end else begin
				pass <= in_key;
			end
		end else if (ctl.pop) begin
			held     <= nxt_key;
			pass.vld <= 1'b0;
		end
	end

endmodule

@@ src/lobm_bank.sv @@
// One side's book: a row of BOOK_DEPTH slots per stock, registered read.
// Depends on lobm_pkg. Row flags make never-written rows read as empty.
module lobm_bank
	import lobm_pkg::*;
#(
	parameter int STOCK_COUNT = STOCK_COUNT_DEF,
	parameter int BOOK_DEPTH  = BOOK_DEPTH_DEF,
	localparam int SW = (STOCK_COUNT > 1) ? $clog2(STOCK_COUNT) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [SW-1:0]                rd_addr,
	output entry_t [BOOK_DEPTH-1:0]      rd_row,
	input  logic                         wr_en,
	input  logic [SW-1:0]                wr_addr,
	input  entry_t [BOOK_DEPTH-1:0]      wr_row
);

	entry_t [BOOK_DEPTH-1:0] mem [STOCK_COUNT];
	entry_t [BOOK_DEPTH-1:0] rd_q;
	logic   [STOCK_COUNT-1:0] row_ok_q;
	logic                     rd_ok_q;

	// row storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// row written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			rd_ok_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_ok_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= row_ok_q[rd_addr];
			end
		end
	end

	// mask slot valid bits of a fresh row
	always_comb begin
		rd_row = rd_q;
		for (int i = 0; i < BOOK_DEPTH; i++) begin
			rd_row[i].vld = rd_q[i].vld & rd_ok_q;
		end
	end

endmodule

@@ src/limit_order_book_matcher_top.sv @@
// Top level of the limit order book matcher: control, chain of sort cells, two books.
// Depends on lobm_pkg, lobm_cell and lobm_bank.
//
// Usage:
//   s_* channel takes one limit order per beat; s_tuser is the side (1 buy).
//   m_* channel gives the trades the order causes, best resting order first,
//   then one closing beat (m_tuser 1, m_tlast 1) with rested amount / drop flag.
//   Per order, from accept to next accept: accept (ST_IDLE), bank read (ST_READ),
//   load of the working row (ST_LOAD), sorting through the cell chain (ST_SORT:
//   feeding the row, then settling), a match step per trade and one that finds
//   no further match (ST_MATCH), then the closing beat (ST_CLOSE); a stalled
//   receiver holds ST_MATCH and ST_CLOSE.
//   One order at a time: s_tready is high only between orders.
//   Results sit in a single output register; while the receiver stalls the
//   matcher waits with the next result and the books are untouched.
//   Reset clears all books (through per-row written flags, no sweep), the
//   arrival counter and the trade count; the block is ready right after reset.
module limit_order_book_matcher_top
	import lobm_pkg::*;
#(
	parameter int STOCK_COUNT = STOCK_COUNT_DEF,
	parameter int BOOK_DEPTH  = BOOK_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [7:0] trader, [11:8] stock, [42:12] limit_price, [73:43] amount, rest zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [0] is_buy
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [7:0] buyer, [15:8] seller, [46:16] trade_price, [77:47] trade_amount,
	// [108:78] rested_amount, [109] dropped, [141:110] trade_total, rest zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// [0] kind
	output logic                   m_tuser,
	output logic                   m_tlast
);

	localparam int SW = (STOCK_COUNT > 1) ? $clog2(STOCK_COUNT) : 1;
	localparam int IW = $clog2(BOOK_DEPTH);
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] LAST_CNT = CW'(2 * BOOK_DEPTH - 1);
	localparam logic [CW-1:0] FEED_END = CW'(BOOK_DEPTH);

	state_t state_q, state_d;

	// order registers
	logic                buy_q;
	logic [TRADER_W-1:0] trader_q;
	logic [SW-1:0]       stock_q;
	logic [PRICE_W-1:0]  limit_q;
	logic [AMT_W-1:0]    left_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [SEQ_W-1:0]    next_seq_q;
	logic [SEQ_W-1:0]    trades_q;
	logic [CW-1:0]       cnt_q;
	logic [IW-1:0]       free_q;
	logic                found_q;
	entry_t [BOOK_DEPTH-1:0] opp_row_q;

	// output register
	logic                   out_vld_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_kind_q;

	// stock number folding table
	logic [SW-1:0] stock_map [STOCK_CODES];
	for (genvar g = 0; g < STOCK_CODES; g++) begin : g_map
		assign stock_map[g] = SW'(g % STOCK_COUNT);
	end

	// banks
	entry_t [BOOK_DEPTH-1:0] buy_rd, sell_rd, opp_rd, own_rd, own_wr;
	entry_t [BOOK_DEPTH-1:0] buy_wr, sell_wr;
	logic rd_en, wr_en;

	lobm_bank #(.STOCK_COUNT(STOCK_COUNT), .BOOK_DEPTH(BOOK_DEPTH)) u_buy_bank (
		.clk, .arst_n,
		.rd_en, .rd_addr(stock_q), .rd_row(buy_rd),
		.wr_en, .wr_addr(stock_q), .wr_row(buy_wr)
	);

	lobm_bank #(.STOCK_COUNT(STOCK_COUNT), .BOOK_DEPTH(BOOK_DEPTH)) u_sell_bank (
		.clk, .arst_n,
		.rd_en, .rd_addr(stock_q), .rd_row(sell_rd),
		.wr_en, .wr_addr(stock_q), .wr_row(sell_wr)
	);

	assign opp_rd = buy_q ? sell_rd : buy_rd;
	assign own_rd = buy_q ? buy_rd : sell_rd;

	// sort chain
	cell_ctl_t ctl;
	key_t      feed;
	key_t      held [BOOK_DEPTH];
	key_t      pass [BOOK_DEPTH-1];
	logic      feeding;
	entry_t    fe;

	assign feeding = cnt_q < FEED_END;
	assign fe      = opp_row_q[cnt_q[IW-1:0]];

	always_comb begin
		feed.vld   = feeding && fe.vld;
		feed.price = fe.price;
		feed.age   = seq_q - fe.seq;
		feed.idx   = SLOT_W'(cnt_q[IW-1:0]);
	end

	for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
		if (i == BOOK_DEPTH - 1) begin : g_tail
			lobm_cell u_cell (
				.clk, .arst_n, .ctl, .is_buy(buy_q),
				.in_key((i == 0) ? feed : pass[i-1]),
				.nxt_key('0),
				.held(held[i]),
				.pass()
			);
		end else begin : g_body
			lobm_cell u_cell (
				.clk, .arst_n, .ctl, .is_buy(buy_q),
				.in_key((i == 0) ? feed : pass[(i == 0) ? 0 : i-1]),
				.nxt_key(held[i+1]),
				.held(held[i]),
				.pass(pass[i])
			);
		end
	end

	// head of the chain against the order
	key_t           head;
	logic [IW-1:0]  hidx;
	entry_t         hent;
	logic [AMT_W-1:0] fill;
	logic           price_ok, trade_ok, can_emit, full_fill;

	assign head      = held[0];
	assign hidx      = head.idx[IW-1:0];
	assign hent      = opp_row_q[hidx];
	assign fill      = (left_q < hent.amount) ? left_q : hent.amount;
	assign full_fill = hent.amount <= left_q;
	assign price_ok  = buy_q ? (head.price <= limit_q) : (head.price >= limit_q);
	assign trade_ok  = (left_q != '0) && head.vld && price_ok;
	assign can_emit  = !out_vld_q || m_tready;

	// closing outcome
	logic rest, drop;
	assign rest = (left_q != '0) && found_q;
	assign drop = (left_q != '0) && !found_q;

	always_comb begin
		own_wr = own_rd;
		if (rest) begin
			own_wr[free_q] = '{vld: 1'b1, price: limit_q, amount: left_q,
			                   trader: trader_q, seq: seq_q};
		end
	end

	assign buy_wr  = buy_q ? own_wr : opp_row_q;
	assign sell_wr = buy_q ? opp_row_q : own_wr;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_READ;
			ST_READ:  state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_SORT;
			ST_SORT:  if (cnt_q == LAST_CNT) state_d = ST_MATCH;
			ST_MATCH: if (!trade_ok) state_d = ST_CLOSE;
			ST_CLOSE: if (can_emit) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	logic do_trade, do_close;
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		ctl      = '0;
		do_trade = 1'b0;
		do_close = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_READ:  rd_en = 1'b1;
			ST_LOAD:  ctl.clr = 1'b1;
			ST_SORT:  ctl.ins = 1'b1;
			ST_MATCH: begin
				do_trade = trade_ok && can_emit;
				ctl.pop  = do_trade && full_fill;
			end
			ST_CLOSE: do_close = can_emit;
			default:  ;
		endcase
	end

	assign wr_en = do_close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// order capture and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q <= '0;
			trades_q   <= '0;
			cnt_q      <= '0;
			found_q    <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				next_seq_q <= next_seq_q + 1'b1;
			end
			if (state_q == ST_LOAD) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else if (state_q == ST_SORT) begin
				cnt_q <= cnt_q + 1'b1;
				if (feeding && !found_q && !own_rd[cnt_q[IW-1:0]].vld) begin
					found_q <= 1'b1;
				end
			end
			if (do_trade) begin
				trades_q <= trades_q + 1'b1;
			end
		end
	end

	// order payload and working row
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			buy_q    <= s_tuser;
			trader_q <= s_tdata[7:0];
			stock_q  <= stock_map[s_tdata[11:8]];
			limit_q  <= s_tdata[42:12];
			left_q   <= s_tdata[73:43];
			seq_q    <= next_seq_q;
		end
		if (state_q == ST_LOAD) begin
			opp_row_q <= opp_rd;
		end
		if (state_q == ST_SORT && feeding && !found_q && !own_rd[cnt_q[IW-1:0]].vld) begin
			free_q <= cnt_q[IW-1:0];
		end
		if (do_trade) begin
			left_q                  <= left_q - fill;
			opp_row_q[hidx].amount  <= hent.amount - fill;
			if (full_fill) begin
				opp_row_q[hidx].vld <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (do_trade || do_close) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_trade) begin
			out_kind_q <= 1'b0;
			out_data_q <= {2'b00, trades_q + 1'b1, 1'b0, {AMT_W{1'b0}}, fill, head.price,
			               buy_q ? hent.trader : trader_q,
			               buy_q ? trader_q : hent.trader};
		end else if (do_close) begin
			out_kind_q <= 1'b1;
			out_data_q <= {2'b00, trades_q, drop, rest ? left_q : {AMT_W{1'b0}},
			               {AMT_W{1'b0}}, {PRICE_W{1'b0}}, {TRADER_W{1'b0}},
			               {TRADER_W{1'b0}}};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_kind_q;

endmodule

@@ src/lobm_checker.sv @@
// Port-level checks for the matcher, bound onto the top level.
// Depends on lobm_pkg and limit_order_book_matcher_top.
module lobm_checker
	import lobm_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed under stall");

	// one order at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("order taken while another is in work");

	// closing beat is the last one and carries no trade
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser) && (!m_tuser || m_tdata[77:0] == '0))
		else $error("closing beat malformed");

	// trade beat moves shares and has no closing fields
	a_trade: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[109:78] == '0 && m_tdata[77:47] != '0)
		else $error("trade beat malformed");

endmodule

bind limit_order_book_matcher_top lobm_checker u_lobm_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking bench for the limit order book matcher: directed orders then random ones.
// Depends on lobm_pkg and limit_order_book_matcher_top; predicts trades and closing beats.
`timescale 1ns / 1ps

module tb_top;
	import lobm_pkg::*;

	localparam int STOCKS = 16;
	localparam int DEPTH  = 32;
	localparam int RANDOM_ORDERS = 290;
	localparam longint CYCLE_LIMIT = 1000000;

	// One limit order
	typedef struct {
		bit        is_buy;
		bit [7:0]  trader;
		bit [3:0]  stock;
		bit [30:0] limit_price;
		bit [30:0] amount;
	} order_t;

	// One output beat
	typedef struct {
		bit        kind;
		bit [7:0]  buyer;
		bit [7:0]  seller;
		bit [30:0] trade_price;
		bit [30:0] trade_amount;
		bit [30:0] rested_amount;
		bit        dropped;
		bit [31:0] trade_total;
		bit        last;
	} fill_t;

	// Directed row: order plus optional typed-in closing beat
	typedef struct {
		order_t    ord;
		bit        chk;
		bit [30:0] rested;
		bit        drop;
	} row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	// Predictor copy of the books
	bit        bk_valid  [STOCKS*2*DEPTH];
	bit [30:0] bk_price  [STOCKS*2*DEPTH];
	bit [30:0] bk_amount [STOCKS*2*DEPTH];
	bit [7:0]  bk_trader [STOCKS*2*DEPTH];
	bit [31:0] bk_seq    [STOCKS*2*DEPTH];
	bit [31:0] arrival_count;
	bit [31:0] trades_seen;

	fill_t  expected_fills[$];
	row_t   rows[$];
	int     errors;
	longint cycles;
	bit     quiet;
	int     stall_left;

	limit_order_book_matcher_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Price-time matching of one order against the predictor books
	function automatic void match_order(input order_t o);
		bit [31:0] sq;
		bit [30:0] left, t, rested;
		int own, opp, best, b, e, slot;
		bit better, drop;
		fill_t f;
		sq = arrival_count;
		arrival_count++;
		left = o.amount;
		own = (o.stock * 2 + o.is_buy) * DEPTH;
		opp = (o.stock * 2 + (o.is_buy ? 0 : 1)) * DEPTH;
		for (int r = 0; r < DEPTH && left != 0; r++) begin
			best = -1;
			for (int i = 0; i < DEPTH; i++) begin
				e = opp + i;
				if (!bk_valid[e]) continue;
				if (best < 0) begin
					best = i;
				end else begin
					b = opp + best;
					if (bk_price[e] == bk_price[b])
						better = (sq - bk_seq[e]) > (sq - bk_seq[b]);
					else
						better = o.is_buy ? bk_price[e] < bk_price[b] : bk_price[e] > bk_price[b];
					if (better) best = i;
				end
			end
			if (best < 0) break;
			b = opp + best;
			if (o.is_buy ? bk_price[b] > o.limit_price : bk_price[b] < o.limit_price) break;
			t = left < bk_amount[b] ? left : bk_amount[b];
			left -= t;
			bk_amount[b] -= t;
			if (bk_amount[b] == 0) bk_valid[b] = 0;
			trades_seen++;
			f = '{default: 0};
			f.buyer = o.is_buy ? o.trader : bk_trader[b];
			f.seller = o.is_buy ? bk_trader[b] : o.trader;
			f.trade_price = bk_price[b];
			f.trade_amount = t;
			f.trade_total = trades_seen;
			expected_fills = {expected_fills, f};
		end
		rested = 0;
		drop = 0;
		if (left != 0) begin
			slot = -1;
			for (int i = 0; i < DEPTH; i++)
				if (!bk_valid[own + i]) begin
					slot = i;
					break;
				end
			if (slot < 0) begin
				drop = 1;
			end else begin
				e = own + slot;
				bk_valid[e] = 1;
				bk_price[e] = o.limit_price;
				bk_amount[e] = left;
				bk_trader[e] = o.trader;
				bk_seq[e] = sq;
				rested = left;
			end
		end
		f = '{default: 0};
		f.kind = 1;
		f.rested_amount = rested;
		f.dropped = drop;
		f.trade_total = trades_seen;
		f.last = 1;
		expected_fills = {expected_fills, f};
	endfunction

	// Send one order; wait for acceptance, then predict
	task automatic send_order(input order_t o);
		int gap;
		if (!quiet && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= o.is_buy;
		s_tdata  <= {6'b0, o.amount, o.limit_price, o.stock, o.trader};
		do @(posedge clk); while (!s_tready);
		match_order(o);
	endtask

	function automatic order_t rand_order(input int n_stocks, input bit wide);
		order_t o;
		o.is_buy = 1'($urandom_range(0, 1));
		o.trader = 8'($urandom);
		o.stock = 4'($urandom_range(0, n_stocks - 1));
		if (wide) begin
			o.limit_price = 31'($urandom_range(1, 32'h7fffffff));
			o.amount = 31'($urandom_range(1, 32'h7fffffff));
		end else begin
			o.limit_price = 31'($urandom_range(95, 105));
			o.amount = 31'($urandom_range(1, 40));
		end
		return o;
	endfunction

	// Receiver: random stalls, compare each beat with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		fill_t g, x;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				g.kind = m_tuser;
				g.buyer = m_tdata[7:0];
				g.seller = m_tdata[15:8];
				g.trade_price = m_tdata[46:16];
				g.trade_amount = m_tdata[77:47];
				g.rested_amount = m_tdata[108:78];
				g.dropped = m_tdata[109];
				g.trade_total = m_tdata[141:110];
				g.last = m_tlast;
				if (expected_fills.size() == 0) begin
					$error("unexpected beat kind=%0d", g.kind);
					errors++;
				end else begin
					x = expected_fills.pop_front();
					if (g.kind != x.kind) begin
						$error("kind exp %0d got %0d", x.kind, g.kind); errors++;
					end
					if (g.buyer != x.buyer) begin
						$error("buyer exp %0d got %0d", x.buyer, g.buyer); errors++;
					end
					if (g.seller != x.seller) begin
						$error("seller exp %0d got %0d", x.seller, g.seller); errors++;
					end
					if (g.trade_price != x.trade_price) begin
						$error("trade_price exp %0d got %0d", x.trade_price, g.trade_price);
						errors++;
					end
					if (g.trade_amount != x.trade_amount) begin
						$error("trade_amount exp %0d got %0d", x.trade_amount, g.trade_amount);
						errors++;
					end
					if (g.rested_amount != x.rested_amount) begin
						$error("rested_amount exp %0d got %0d", x.rested_amount,
							g.rested_amount);
						errors++;
					end
					if (g.dropped != x.dropped) begin
						$error("dropped exp %0d got %0d", x.dropped, g.dropped); errors++;
					end
					if (g.trade_total != x.trade_total) begin
						$error("trade_total exp %0d got %0d", x.trade_total, g.trade_total);
						errors++;
					end
					if (g.last != x.last) begin
						$error("last exp %0d got %0d", x.last, g.last); errors++;
					end
				end
			end
			// random stall bursts, none late in the run
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				m_tready <= (stall_left == 0);
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Timeout watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Directed table: extremes, drops on a full book, zero-price corner avoided by range
	task automatic build_rows();
		row_t r;
		r = '{default: 0};
		// first order after reset rests whole
		r.ord = '{is_buy: 1, trader: 8'hff, stock: 4'd15, limit_price: 31'h7fffffff,
			amount: 31'h7fffffff};
		r.chk = 1; r.rested = 31'h7fffffff; r.drop = 0;
		rows = {rows, r};
		// sell at minimum price sweeps it
		r.ord = '{is_buy: 0, trader: 8'h00, stock: 4'd15, limit_price: 31'd1,
			amount: 31'h7fffffff};
		r.chk = 0;
		rows = {rows, r};
		r.ord = '{is_buy: 0, trader: 8'h55, stock: 4'd0, limit_price: 31'd1, amount: 31'd1};
		r.chk = 1; r.rested = 1; r.drop = 0;
		rows = {rows, r};
		r.ord = '{is_buy: 1, trader: 8'haa, stock: 4'd0, limit_price: 31'd1, amount: 31'd3};
		r.chk = 0;
		rows = {rows, r};
		// fill stock 3 buy book, then two more buys get dropped
		for (int i = 0; i < DEPTH + 2; i++) begin
			r.ord = '{is_buy: 1, trader: i[7:0], stock: 4'd3, limit_price: 31'd50 + i[30:0] % 3,
				amount: 31'd10};
			r.chk = (i >= DEPTH); r.rested = 0; r.drop = 1;
			if (i < 20 || i >= DEPTH) rows = {rows, r};
			else begin
				r.chk = 0;
				rows = {rows, r};
			end
		end
	endtask

	initial begin
		order_t o;
		errors = 0;
		cycles = 0;
		quiet = 0;
		arrival_count = 0;
		trades_seen = 0;
		for (int i = 0; i < STOCKS*2*DEPTH; i++) bk_valid[i] = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		build_rows();
		foreach (rows[k]) begin
			send_order(rows[k].ord);
			if (rows[k].chk) begin
				if (expected_fills[$].rested_amount != rows[k].rested
					|| expected_fills[$].dropped != rows[k].drop) begin
					$error("table row %0d: rested exp %0d drop exp %0d", k, rows[k].rested,
						rows[k].drop);
					errors++;
				end
			end
		end
		// sweep the full buy book with a big sell, whose remainder rests on the sell side
		o = '{is_buy: 0, trader: 8'h77, stock: 4'd3, limit_price: 31'd1, amount: 31'd1000};
		send_order(o);
		// random: mostly crossing prices, in runs of 25 orders on two stocks then on all 16, some wide-range noise
		for (int n = 0; n < RANDOM_ORDERS; n++) begin
			if (n > RANDOM_ORDERS - 40) quiet = 1;
			send_order(rand_order(n % 50 < 25 ? 2 : 16, $urandom_range(0, 9) == 0));
		end
		s_tvalid <= 1'b0;
		while (expected_fills.size() != 0) @(posedge clk);
		repeat (2*DEPTH + 40) @(posedge clk);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule

@@ limit_order_book_matcher_top.f @@
src/lobm_pkg.sv
src/lobm_cell.sv
src/lobm_bank.sv
src/limit_order_book_matcher_top.sv
src/lobm_checker.sv
sim/tb_top.sv
